### src/fxa_pkg.sv
// Shared constants and types for the Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
package fxa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    // Rounded-division numerator 2*|a|*2^F + |b| and doubled divisor widths
    localparam int NUM_W     = DATA_W + FRAC_BITS + 1;
    localparam int DEN_W     = DATA_W + 1;
    localparam int REM_W     = DEN_W + 1;
    localparam int PROD_W    = 2 * DATA_W;

    localparam logic [PROD_W-1:0] MUL_HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [PROD_W-1:0] POS_MAX  = PROD_W'({1'b0, {(DATA_W-1){1'b1}}});
    localparam logic [PROD_W-1:0] NEG_MAX  = PROD_W'({1'b1, {(DATA_W-1){1'b0}}});

    typedef enum logic [3:0] {
        ACT_ADD      = 4'd0,
        ACT_SUB      = 4'd1,
        ACT_MUL      = 4'd2,
        ACT_DIV      = 4'd3,
        ACT_GT       = 4'd4,
        ACT_LT       = 4'd5,
        ACT_GE       = 4'd6,
        ACT_LE       = 4'd7,
        ACT_EQ       = 4'd8,
        ACT_NE       = 4'd9,
        ACT_MIN      = 4'd10,
        ACT_MAX      = 4'd11,
        ACT_INC      = 4'd12,
        ACT_DEC      = 4'd13,
        ACT_TO_INT   = 4'd14,
        ACT_FROM_INT = 4'd15
    } t_action;

    // Per-word control that rides along with the pipeline
    typedef struct packed {
        t_action             action;
        logic [DATA_W-1:0]   res;
        logic                cmp;
        logic                dz;
        logic                neg;
    } t_ctl;

endpackage

### src/fixed_point_q24_8_alu.sv
// Top level: fully pipelined Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
// Usage:
//   Input channel: drive i_action, i_operand_a and i_operand_b and raise
//   start; the word is taken at the rising edge where start is high and
//   busy is low. busy is always low, so a new word may enter every cycle.
//   Output channel: o_valid marks one result word for exactly one cycle on
//   o_result, o_compare_true, o_saturated and o_divide_by_zero. The receiver
//   cannot hold results off, and none is needed: the pipeline never stalls.
// Ordering and throughput:
//   Every action takes the same path so results leave in order. The
//   pipeline depth is set by the restoring divider, one quotient bit
//   per stage over the NUM_W-bit (41-bit for Q24.8) rounded numerator.
//   Throughput is one word per cycle. Multiply uses one 32x32 multiplier
//   in its own stage, then a rounding add; both results round half away
//   from zero and saturate.
// Reset:
//   i_rst_n (synchronous, active low) clears every valid bit, dropping
//   words in flight; datapath registers are not reset.
module fixed_point_q24_8_alu import fxa_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [3:0]               i_action,
    input  logic signed [DATA_W-1:0] i_operand_a,
    input  logic signed [DATA_W-1:0] i_operand_b,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_result,
    output logic                     o_compare_true,
    output logic                     o_saturated,
    output logic                     o_divide_by_zero
);

    // Stage 0: input capture
    logic              r_s0_vld;
    t_action           r_s0_act;
    logic [DATA_W-1:0] r_s0_a, r_s0_b;

    // Stage 1: magnitudes, simple results, divider operands
    logic              r_s1_vld;
    t_ctl              r_s1_ctl, n_s1_ctl;
    logic [DATA_W-1:0] r_s1_ma, r_s1_mb;
    logic [NUM_W-1:0]  r_s1_num;
    logic [DEN_W-1:0]  r_s1_den;

    // Stage 2: full product
    logic              r_s2_vld;
    t_ctl              r_s2_ctl;
    logic [PROD_W-1:0] r_s2_prod;
    logic [NUM_W-1:0]  r_s2_num;
    logic [DEN_W-1:0]  r_s2_den;

    // Divider stages 0..NUM_W; index 0 also takes the rounded product
    logic              r_dv_vld [0:NUM_W];
    t_ctl              r_dv_ctl [0:NUM_W];
    logic [PROD_W-1:0] r_dv_mul [0:NUM_W];
    logic [DEN_W-1:0]  r_dv_den [0:NUM_W];
    logic [DEN_W-1:0]  r_dv_rem [0:NUM_W];
    logic [NUM_W-1:0]  r_dv_quo [0:NUM_W];

    logic              n_o_valid;
    logic [DATA_W-1:0] n_o_result;
    logic              n_o_sat;

    assign busy = 1'b0;

    // ---- Stage 0 ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_act <= t_action'(i_action);
        r_s0_a   <= i_operand_a;
        r_s0_b   <= i_operand_b;
    end

    // ---- Stage 1 ----
    logic [DATA_W-1:0] s1_ma, s1_mb;
    logic              s1_le, s1_ge;

    always_comb begin
        s1_ma = r_s0_a[DATA_W-1] ? DATA_W'(-r_s0_a) : r_s0_a;
        s1_mb = r_s0_b[DATA_W-1] ? DATA_W'(-r_s0_b) : r_s0_b;
        s1_le = $signed(r_s0_a) <= $signed(r_s0_b);
        s1_ge = $signed(r_s0_a) >= $signed(r_s0_b);

        n_s1_ctl        = '0;
        n_s1_ctl.action = r_s0_act;
        n_s1_ctl.neg    = r_s0_a[DATA_W-1] ^ r_s0_b[DATA_W-1];
        case (r_s0_act)
            ACT_ADD:      n_s1_ctl.res = r_s0_a + r_s0_b;
            ACT_SUB:      n_s1_ctl.res = r_s0_a - r_s0_b;
            ACT_DIV:      n_s1_ctl.dz  = (r_s0_b == '0);
            ACT_GT:       n_s1_ctl.cmp = !s1_le;
            ACT_LT:       n_s1_ctl.cmp = !s1_ge;
            ACT_GE:       n_s1_ctl.cmp = s1_ge;
            ACT_LE:       n_s1_ctl.cmp = s1_le;
            ACT_EQ:       n_s1_ctl.cmp = (r_s0_a == r_s0_b);
            ACT_NE:       n_s1_ctl.cmp = (r_s0_a != r_s0_b);
            ACT_MIN:      n_s1_ctl.res = s1_le ? r_s0_a : r_s0_b;
            ACT_MAX:      n_s1_ctl.res = s1_ge ? r_s0_a : r_s0_b;
            ACT_INC:      n_s1_ctl.res = r_s0_a + DATA_W'(1);
            ACT_DEC:      n_s1_ctl.res = r_s0_a - DATA_W'(1);
            ACT_TO_INT:   n_s1_ctl.res = DATA_W'($signed(r_s0_a) >>> FRAC_BITS);
            ACT_FROM_INT: n_s1_ctl.res = r_s0_a << FRAC_BITS;
            default:      n_s1_ctl.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ctl <= n_s1_ctl;
        r_s1_ma  <= s1_ma;
        r_s1_mb  <= s1_mb;
        // Round half away: (2*num + den) / (2*den)
        r_s1_num <= (NUM_W'(s1_ma) << (FRAC_BITS + 1)) + NUM_W'(s1_mb);
        r_s1_den <= {s1_mb, 1'b0};
    end

    // ---- Stage 2: multiply ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_ctl  <= r_s1_ctl;
        r_s2_prod <= PROD_W'(r_s1_ma) * PROD_W'(r_s1_mb);
        r_s2_num  <= r_s1_num;
        r_s2_den  <= r_s1_den;
    end

    // ---- Divider entry plus product rounding ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else begin
            r_dv_vld[0] <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_ctl[0] <= r_s2_ctl;
        r_dv_mul[0] <= (r_s2_prod + MUL_HALF) >> FRAC_BITS;
        r_dv_den[0] <= r_s2_den;
        r_dv_rem[0] <= '0;
        r_dv_quo[0] <= r_s2_num;
    end

    // ---- Restoring divider: one quotient bit per stage ----
    for (genvar g = 0; g < NUM_W; g++) begin : g_div
        logic [REM_W-1:0] trial;
        logic             take;

        always_comb begin
            trial = {r_dv_rem[g], r_dv_quo[g][NUM_W-1]};
            take  = trial >= REM_W'(r_dv_den[g]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[g+1] <= 1'b0;
            end else begin
                r_dv_vld[g+1] <= r_dv_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_ctl[g+1] <= r_dv_ctl[g];
            r_dv_mul[g+1] <= r_dv_mul[g];
            r_dv_den[g+1] <= r_dv_den[g];
            r_dv_rem[g+1] <= take ? DEN_W'(trial - REM_W'(r_dv_den[g])) : DEN_W'(trial);
            r_dv_quo[g+1] <= {r_dv_quo[g][NUM_W-2:0], take};
        end
    end

    // ---- Final select and saturation ----
    t_ctl              fin_ctl;
    logic [PROD_W-1:0] fin_mag;
    logic              fin_md;
    logic              fin_neg;

    always_comb begin
        fin_ctl    = r_dv_ctl[NUM_W];
        fin_md     = (fin_ctl.action == ACT_MUL) ||
                     ((fin_ctl.action == ACT_DIV) && !fin_ctl.dz);
        fin_mag    = (fin_ctl.action == ACT_MUL) ? r_dv_mul[NUM_W]
                                                 : PROD_W'(r_dv_quo[NUM_W]);
        fin_neg    = fin_ctl.neg && (fin_mag != '0);
        n_o_sat    = 1'b0;
        n_o_result = fin_ctl.res;
        n_o_valid  = r_dv_vld[NUM_W];
        if (fin_md) begin
            if (!fin_neg) begin
                if (fin_mag > POS_MAX) begin
                    n_o_sat    = 1'b1;
                    n_o_result = POS_MAX[DATA_W-1:0];
                end else begin
                    n_o_result = fin_mag[DATA_W-1:0];
                end
            end else begin
                if (fin_mag > NEG_MAX) begin
                    n_o_sat    = 1'b1;
                    n_o_result = NEG_MAX[DATA_W-1:0];
                end else begin
                    n_o_result = DATA_W'(-fin_mag[DATA_W-1:0]);
                end
            end
        end
    end

    // Hold each result word for exactly one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result         <= n_o_result;
        o_compare_true   <= fin_ctl.cmp;
        o_saturated      <= n_o_sat;
        o_divide_by_zero <= fin_ctl.dz;
    end

endmodule

### verif/tb.sv
// Self-checking testbench for the Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
module tb;
    import fxa_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  i_action;
    logic signed [31:0] i_operand_a;
    logic signed [31:0] i_operand_b;
    logic        o_valid;
    logic signed [31:0] o_result;
    logic        o_compare_true;
    logic        o_saturated;
    logic        o_divide_by_zero;

    // One expected output word
    typedef struct {
        logic [31:0] res;
        logic        cmp;
        logic        sat;
        logic        dz;
    } t_alu_word;

    // One stimulus row; chk says the expected word was typed in by hand
    typedef struct {
        t_action     act;
        logic [31:0] a;
        logic [31:0] b;
        bit          chk;
        t_alu_word   want;
    } t_row;

    t_alu_word expected_words[$];
    int        n_errors;
    int        n_words_seen;
    int        n_words_sent;

    fixed_point_q24_8_alu DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_operand_a      (i_operand_a),
        .i_operand_b      (i_operand_b),
        .o_valid          (o_valid),
        .o_result         (o_result),
        .o_compare_true   (o_compare_true),
        .o_saturated      (o_saturated),
        .o_divide_by_zero (o_divide_by_zero)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Clip a signed magnitude to 32 bits, flagging when it does not fit
    function automatic logic [31:0] clip_q(input bit neg, input logic [63:0] mag,
                                           inout logic sat);
        if (!neg) begin
            if (mag > 64'h7FFF_FFFF) begin
                sat = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return mag[31:0];
        end
        if (mag > 64'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return 32'(64'd0 - mag);
    endfunction

    // Compute what the ALU should return for one word
    function automatic t_alu_word alu_predict(input t_action act,
                                              input logic [31:0] ua,
                                              input logic [31:0] ub);
        t_alu_word   w;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] mag;
        bit          neg;
        sa = ua;
        sb = ub;
        w = '{res: '0, cmp: 1'b0, sat: 1'b0, dz: 1'b0};
        ma = sa[31] ? 64'd0 - {{32{1'b1}}, ua} : {32'd0, ua};
        mb = sb[31] ? 64'd0 - {{32{1'b1}}, ub} : {32'd0, ub};
        neg = sa[31] != sb[31];
        case (act)
            ACT_ADD:  w.res = ua + ub;
            ACT_SUB:  w.res = ua - ub;
            ACT_MUL: begin
                mag = (ma * mb + 64'd128) >> FRAC_BITS;
                if (mag == 0) neg = 0;
                w.res = clip_q(neg, mag, w.sat);
            end
            ACT_DIV: begin
                if (ub == 0) begin
                    w.dz = 1'b1;
                end else begin
                    mag = (2 * (ma << FRAC_BITS) + mb) / (2 * mb);
                    if (mag == 0) neg = 0;
                    w.res = clip_q(neg, mag, w.sat);
                end
            end
            ACT_GT:   w.cmp = sa > sb;
            ACT_LT:   w.cmp = sa < sb;
            ACT_GE:   w.cmp = sa >= sb;
            ACT_LE:   w.cmp = sa <= sb;
            ACT_EQ:   w.cmp = sa == sb;
            ACT_NE:   w.cmp = sa != sb;
            ACT_MIN:  w.res = (sa <= sb) ? ua : ub;
            ACT_MAX:  w.res = (sa >= sb) ? ua : ub;
            ACT_INC:  w.res = ua + 1;
            ACT_DEC:  w.res = ua - 1;
            ACT_TO_INT: w.res = sa >>> FRAC_BITS;
            default:  w.res = ua << FRAC_BITS;
        endcase
        return w;
    endfunction

    // Compare each strobed word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            n_words_seen++;
            if (expected_words.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected word res=%h cmp=%b sat=%b dz=%b",
                             o_result, o_compare_true, o_saturated, o_divide_by_zero);
            end else begin
                t_alu_word w;
                w = expected_words.pop_front();
                if (o_result !== w.res || o_compare_true !== w.cmp ||
                    o_saturated !== w.sat || o_divide_by_zero !== w.dz) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display({"ERROR: word %0d exp res=%h cmp=%b sat=%b dz=%b",
                                  " got res=%h cmp=%b sat=%b dz=%b"},
                                 n_words_seen, w.res, w.cmp, w.sat, w.dz, o_result,
                                 o_compare_true, o_saturated, o_divide_by_zero);
                end
            end
        end
    end

    // Drive one word at the falling edge and hold it until accepted;
    // start stays high afterward, the caller drops it for idle cycles
    task automatic send_word(input t_action act, input logic [31:0] a,
                             input logic [31:0] b, input bit chk,
                             input t_alu_word want);
        t_alu_word p;
        p = alu_predict(act, a, b);
        if (chk && (p.res !== want.res || p.cmp !== want.cmp ||
                    p.sat !== want.sat || p.dz !== want.dz)) begin
            n_errors++;
            if (n_errors <= 10)
                $display("ERROR: table row %0d act=%0d predictor disagrees",
                         n_words_sent, act);
        end
        start       <= 1'b1;
        i_action    <= act;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_words.push_back(chk ? want : p);
        n_words_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 1023) - 512;
            3: return $urandom_range(0, 8) << FRAC_BITS;
            default: return $urandom;
        endcase
    endfunction

    t_row table_rows[$];
    initial begin : stimulus
        t_alu_word z;
        int        gap;
        bit        quiet;
        bit        idle;
        t_action   act;
        z = '{res: '0, cmp: 1'b0, sat: 1'b0, dz: 1'b0};
        n_errors = 0;
        n_words_seen = 0;
        n_words_sent = 0;
        start = 1'b0;
        i_action = '0;
        i_operand_a = '0;
        i_operand_b = '0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Extremes and error codes are typed in; the rest go by the predictor
        table_rows = '{
            '{ACT_ADD, 32'h7FFF_FFFF, 32'h1, 1, '{32'h8000_0000, 0, 0, 0}},
            '{ACT_SUB, 32'h8000_0000, 32'h1, 1, '{32'h7FFF_FFFF, 0, 0, 0}},
            '{ACT_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, '{32'h7FFF_FFFF, 0, 1, 0}},
            '{ACT_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 1, '{32'h8000_0000, 0, 1, 0}},
            '{ACT_MUL, 32'h0000_0180, 32'hFFFF_FF80, 0, z},
            '{ACT_MUL, 32'h0000_0001, 32'h0000_0080, 1, '{32'h1, 0, 0, 0}},
            '{ACT_MUL, 32'hFFFF_FFFF, 32'h0000_0080, 1, '{32'hFFFF_FFFF, 0, 0, 0}},
            '{ACT_DIV, 32'h0000_1234, 32'h0, 1, '{32'h0, 0, 0, 1}},
            '{ACT_DIV, 32'h8000_0000, 32'h0, 1, '{32'h0, 0, 0, 1}},
            '{ACT_DIV, 32'h7FFF_FFFF, 32'h1, 1, '{32'h7FFF_FFFF, 0, 1, 0}},
            '{ACT_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1, '{32'h7FFF_FFFF, 0, 1, 0}},
            '{ACT_DIV, 32'h0000_0300, 32'hFFFF_FE00, 0, z},
            '{ACT_GT,  32'h8000_0000, 32'h7FFF_FFFF, 1, '{32'h0, 0, 0, 0}},
            '{ACT_LT,  32'h8000_0000, 32'h7FFF_FFFF, 1, '{32'h0, 1, 0, 0}},
            '{ACT_GE,  32'h5, 32'h5, 1, '{32'h0, 1, 0, 0}},
            '{ACT_LE,  32'h6, 32'h5, 1, '{32'h0, 0, 0, 0}},
            '{ACT_EQ,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{32'h0, 1, 0, 0}},
            '{ACT_NE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{32'h0, 0, 0, 0}},
            '{ACT_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 1, '{32'h8000_0000, 0, 0, 0}},
            '{ACT_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1, '{32'h7FFF_FFFF, 0, 0, 0}},
            '{ACT_INC, 32'h7FFF_FFFF, 32'h0, 1, '{32'h8000_0000, 0, 0, 0}},
            '{ACT_DEC, 32'h8000_0000, 32'h0, 1, '{32'h7FFF_FFFF, 0, 0, 0}},
            '{ACT_TO_INT, 32'hFFFF_FF01, 32'h0, 1, '{32'hFFFF_FFFF, 0, 0, 0}},
            '{ACT_FROM_INT, 32'h0080_0001, 32'hFFFF_FFFF, 1, '{32'h8000_0100, 0, 0, 0}}
        };
        foreach (table_rows[i])
            send_word(table_rows[i].act, table_rows[i].a, table_rows[i].b,
                      table_rows[i].chk, table_rows[i].want);

        // Random words; idle bursts come and go, the last stretch runs solid
        for (int k = 0; k < 1750; k++) begin
            quiet = (k >= 1500);
            idle  = !quiet && ($urandom_range(0, 2) == 0);
            act = t_action'($urandom_range(0, 15));
            send_word(act, rand_operand(),
                      ($urandom_range(0, 15) == 0) ? 32'h0 : rand_operand(),
                      0, z);
            if (idle) begin
                start <= 1'b0;
                gap = $urandom_range(1, 6);
                repeat (gap) @(negedge i_clk);
            end
        end
        start <= 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Covered %0d words over all 16 actions, %0d results checked.",
                 n_words_sent, n_words_seen);
        if (n_errors == 0 && expected_words.size() == 0)
            $display("PASS fixed_point_q24_8_alu");
        else
            $display("FAIL fixed_point_q24_8_alu");
        $finish;
    end

    // Drop the run if it hangs
    initial begin
        #2000000;
        $display("FAIL fixed_point_q24_8_alu");
        $finish;
    end
endmodule

### sim.f
src/fxa_pkg.sv
src/fixed_point_q24_8_alu.sv
verif/tb.sv
